// ===== src/cla_pkg.sv =====
// types and constants shared by the charge loss alarm controller files
`timescale 1ns / 1ps
`default_nettype none

package cla_pkg;

    typedef logic [7:0]  adc_code_t;
    typedef logic [2:0]  mode_t;
    typedef logic [13:0] millivolt_t;
    typedef logic [2:0]  cfg_index_t;
    typedef logic [13:0] cfg_data_t;

    // mode codes
    localparam mode_t MODE_STARTUP          = 3'd0;
    localparam mode_t MODE_CAR_ON_PHONE_OFF  = 3'd1;
    localparam mode_t MODE_CAR_ON_PHONE_ON   = 3'd2;
    localparam mode_t MODE_CAR_OFF_PHONE_ON  = 3'd3;
    localparam mode_t MODE_CAR_OFF_PHONE_OFF = 3'd4;

    // register indexes
    localparam cfg_index_t REG_HIGH_LIMIT    = 3'd0;
    localparam cfg_index_t REG_LOW_LIMIT     = 3'd1;
    localparam cfg_index_t REG_STARTUP_BLINK = 3'd2;
    localparam cfg_index_t REG_ARM_AFTER     = 3'd3;
    localparam cfg_index_t REG_FAST_WINDOW   = 3'd4;

    // register reset values
    localparam logic [13:0] HIGH_LIMIT_RESET    = 14'd14600;
    localparam logic [13:0] LOW_LIMIT_RESET     = 14'd14300;
    localparam logic [6:0]  STARTUP_BLINK_RESET = 7'd6;
    localparam logic [7:0]  ARM_AFTER_RESET     = 8'd249;
    localparam logic [7:0]  FAST_WINDOW_RESET   = 8'd200;

endpackage

`default_nettype wire

// ===== src/cla_if.sv =====
// valid/ready channel interfaces for tick samples and alarm results
`timescale 1ns / 1ps
`default_nettype none

interface cla_sample_if
    import cla_pkg::*;
();
    logic      valid;
    logic      ready;
    adc_code_t adc_code;
    logic      phone_on_pad;

    modport source (output valid, output adc_code, output phone_on_pad, input ready);
    modport sink   (input valid, input adc_code, input phone_on_pad, output ready);
endinterface

interface cla_result_if
    import cla_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  led_lit;
    mode_t mode_code;
    logic  armed;

    modport source (output valid, output led_lit, output mode_code, output armed, input ready);
    modport sink   (input valid, input led_lit, input mode_code, input armed, output ready);
endinterface

`default_nettype wire

// ===== src/charge_loss_alarm_controller.sv =====
// charge loss alarm controller: tick counter, voltage latch and five-mode led machine
// path: each sample passes the input register and then the result register
// throughput: one tick per cycle; the result register and input register stall together
// only while a result waits and the input register is also full
// reset: block state and valid flags cleared, mode startup, led off, limits back to their default values
// no clearing pass: all block state sits in flip-flops cleared by rst_n at once
`timescale 1ns / 1ps
`default_nettype none

module charge_loss_alarm_controller
    import cla_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    cla_sample_if.sink      sample,
    cla_result_if.source    result,
    input  wire logic       wr_en,
    input  wire cfg_index_t wr_index,
    input  wire cfg_data_t  wr_data
);

    // configuration registers
    logic [13:0] high_limit_reg;
    logic [13:0] low_limit_reg;
    logic [6:0]  startup_blink_reg;
    logic [7:0]  arm_after_reg;
    logic [7:0]  fast_window_reg;

    // input register
    logic      in_valid_reg;
    adc_code_t in_code_reg;
    logic      in_phone_reg;

    // block state
    logic [7:0] tick_reg,     tick_next;
    mode_t      mode_reg,     mode_next;
    logic       led_reg,      led_next;
    logic [7:0] blink_reg,    blink_next;
    logic       finished_reg, finished_next;
    logic       armed_reg,    armed_next;
    millivolt_t volt_reg,     volt_next;

    // result register
    logic  out_valid_reg;
    logic  out_led_reg;
    mode_t out_mode_reg;
    logic  out_armed_reg;

    logic advance;   // input register may hand its tick on this cycle
    logic fire;      // the held tick is worked and its result loaded
    logic latch_volt;

    assign advance      = !out_valid_reg || result.ready;
    assign fire         = in_valid_reg && advance;
    assign sample.ready = !in_valid_reg || advance;

    assign result.valid     = out_valid_reg;
    assign result.led_lit   = out_led_reg;
    assign result.mode_code = out_mode_reg;
    assign result.armed     = out_armed_reg;

    // configuration writes, out-of-range indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_limit_reg    <= HIGH_LIMIT_RESET;
            low_limit_reg     <= LOW_LIMIT_RESET;
            startup_blink_reg <= STARTUP_BLINK_RESET;
            arm_after_reg     <= ARM_AFTER_RESET;
            fast_window_reg   <= FAST_WINDOW_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_HIGH_LIMIT:    high_limit_reg    <= wr_data;
                REG_LOW_LIMIT:     low_limit_reg     <= wr_data;
                REG_STARTUP_BLINK: startup_blink_reg <= wr_data[6:0];
                REG_ARM_AFTER:     arm_after_reg     <= wr_data[7:0];
                REG_FAST_WINDOW:   fast_window_reg   <= wr_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register: a new transaction loads whenever ready is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_code_reg  <= sample.adc_code;
            in_phone_reg <= sample.phone_on_pad;
        end
    end

    // per-tick update
    always_comb
    begin
        tick_next     = tick_reg + 8'd1;
        armed_next    = armed_reg || (tick_next > arm_after_reg);
        // count modulo 50 equals 1 within an 8-bit count
        latch_volt    = (tick_next == 8'd1)   || (tick_next == 8'd51)  ||
                        (tick_next == 8'd101) || (tick_next == 8'd151) ||
                        (tick_next == 8'd201) || (tick_next == 8'd251);
        volt_next     = latch_volt ? {in_code_reg, 6'b000000} : volt_reg;
        mode_next     = mode_reg;
        led_next      = led_reg;
        blink_next    = blink_reg;
        finished_next = finished_reg;

        unique case (mode_reg)
            MODE_STARTUP:
            begin
                if (finished_reg && !in_phone_reg)
                begin
                    finished_next = 1'b0;
                    led_next      = 1'b0;
                    mode_next     = MODE_CAR_ON_PHONE_OFF;
                end
                else if (in_phone_reg)
                begin
                    finished_next = 1'b0;
                    led_next      = 1'b0;
                    mode_next     = MODE_CAR_ON_PHONE_ON;
                end
                else if (blink_reg < {startup_blink_reg, 1'b0})
                begin
                    // slow blink on count modulo 64 equal to 1
                    if (tick_next[5:0] == 6'd1)
                    begin
                        led_next   = !led_reg;
                        blink_next = blink_reg + 8'd1;
                    end
                end
                else
                begin
                    finished_next = 1'b1;
                    blink_next    = 8'd0;
                end
            end
            MODE_CAR_ON_PHONE_OFF:
            begin
                if (in_phone_reg)
                    mode_next = MODE_CAR_ON_PHONE_ON;
                else if (volt_next < low_limit_reg)
                    mode_next = MODE_CAR_OFF_PHONE_OFF;
            end
            MODE_CAR_ON_PHONE_ON:
            begin
                if (!in_phone_reg)
                    mode_next = MODE_CAR_ON_PHONE_OFF;
                else if (volt_next < low_limit_reg)
                    mode_next = MODE_CAR_OFF_PHONE_ON;
            end
            MODE_CAR_OFF_PHONE_ON:
            begin
                if (!in_phone_reg)
                begin
                    led_next  = 1'b0;
                    mode_next = MODE_CAR_OFF_PHONE_OFF;
                end
                else if (volt_next > high_limit_reg)
                begin
                    led_next  = 1'b0;
                    mode_next = MODE_CAR_ON_PHONE_ON;
                end
                else if (armed_next)
                begin
                    // fast blink every fourth tick inside the window
                    if (tick_next < fast_window_reg)
                    begin
                        if (tick_next[1:0] == 2'd0)
                            led_next = !led_reg;
                    end
                    else
                    begin
                        led_next = 1'b0;
                    end
                end
            end
            MODE_CAR_OFF_PHONE_OFF:
            begin
                if (in_phone_reg)
                    mode_next = MODE_CAR_OFF_PHONE_ON;
                else if (volt_next > high_limit_reg)
                    mode_next = MODE_CAR_ON_PHONE_OFF;
            end
            default:
            begin
                // unreachable codes leave the machine untouched
            end
        endcase
    end

    // block state advances once per worked tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= 8'd0;
            mode_reg     <= MODE_STARTUP;
            led_reg      <= 1'b0;
            blink_reg    <= 8'd0;
            finished_reg <= 1'b0;
            armed_reg    <= 1'b0;
            volt_reg     <= '0;
        end
        else if (fire)
        begin
            tick_reg     <= tick_next;
            mode_reg     <= mode_next;
            led_reg      <= led_next;
            blink_reg    <= blink_next;
            finished_reg <= finished_next;
            armed_reg    <= armed_next;
            volt_reg     <= volt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_led_reg   <= led_next;
            out_mode_reg  <= mode_next;
            out_armed_reg <= armed_next;
        end
    end

    // once armed the alarm never disarms
    assert property (@(posedge clk) disable iff (!rst_n) armed_reg |=> armed_reg)
        else $error("alarm disarmed");

    // startup is never re-entered
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_STARTUP) |=> (mode_reg != MODE_STARTUP))
        else $error("startup mode re-entered");

    // an empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid_reg |-> sample.ready)
        else $error("input stalled with empty result register");

    // a loaded result reports the mode the state holds
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_mode_reg == mode_reg) && (out_armed_reg == armed_reg))
        else $error("result register out of step with state");

endmodule

`default_nettype wire
